// ===== sv/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the two-heap running median
// Widths, depths and the controller state and command types.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int CAPACITY     = 1024;
   localparam int HALF_DEPTH   = (CAPACITY + 1) / 2;
   localparam int ADDR_WIDTH   = $clog2(HALF_DEPTH);
   localparam int SIZE_WIDTH   = $clog2(HALF_DEPTH + 1);
   localparam int COUNT_WIDTH  = 11;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [ADDR_WIDTH-1:0]          addr_type;
   typedef logic [SIZE_WIDTH-1:0]          size_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOP_RD,     // read source heap top
      ST_TOP_CHK,    // decide exchange
      ST_DN_RD,      // read children
      ST_DN_RD2,
      ST_DN_CHK,     // compare with children
      ST_UP_RD,      // read parent on destination heap
      ST_UP_CHK,
      ST_FIN_RD,     // read both tops for the median
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic ld_top;
      logic dn_rd_left;
      logic dn_rd_right;
      logic dn_step;
      logic dn_end;
      logic up_begin;
      logic up_rd;
      logic up_step;
      logic up_end;
      logic fin_rd;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic src_empty;
      logic top_exch;
      logic dn_has_left;
      logic dn_has_right;
      logic dn_swap;
      logic up_at_root;
      logic up_swap;
   } sts_type;

endpackage

// ===== sv/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps: streaming running median over two heaps
// Max-heap holds the lower half, min-heap the upper half; one result per sample.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)               | tuser
//  req     | in  | sample[31:0]                             | -
//  rsp     | out | median[31:0], sample_count[42:32]         | dropped
//
//  A dropped sample goes straight to the median read. Otherwise the sample is
//  compared with the source heap top (not when that heap is empty); on an
//  exchange the source heap sifts down, then the destination heap sifts up,
//  one compare at a time through the single port of each heap RAM.
//  Reset: synchronous, clears heap sizes and controller; heap RAM is not cleared.
//  A new sample is taken only from the cycle after the previous result's
//  transfer on; a stalled result holds the input off until taken.
// ----------------------------------------------------------------------------
module running_median_two_heaps (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // median[31:0], sample_count[42:32], zero pad
   output logic        rsp_tuser    // dropped
);
   rmth_pkg::cmd_type    cmd;
   rmth_pkg::sts_type    sts;
   rmth_pkg::sample_type median;
   logic [rmth_pkg::COUNT_WIDTH-1:0] count;
   logic                 dropped;

   rmth_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd));

   rmth_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sample(req_tdata),
      .sts(sts), .median(median), .count(count), .dropped(dropped));

   // result fields stay stable from FIN until the transfer, no new start meanwhile
   assign rsp_tdata = {5'b0, count, median};
   assign rsp_tuser = dropped;
endmodule

// ===== sv/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/rmth_datapath.sv =====
// ----------------------------------------------------------------------------
// rmth_datapath: heap memories, sizes, sift registers and median
// Source heap takes an exchange and sift-down; destination heap a sift-up.
// ----------------------------------------------------------------------------
module rmth_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rmth_pkg::cmd_type   cmd,
   input  rmth_pkg::sample_type sample,
   output rmth_pkg::sts_type   sts,
   output rmth_pkg::sample_type median,
   output logic [rmth_pkg::COUNT_WIDTH-1:0] count,
   output logic                dropped
);
   localparam int AW = rmth_pkg::ADDR_WIDTH;
   localparam int SW = rmth_pkg::SIZE_WIDTH;

   rmth_pkg::size_type   lo_size_ff, lo_size_in, up_size_ff, up_size_in;
   logic                 src_lo_ff, src_lo_in;   // 1: source is max-heap
   rmth_pkg::sample_type x_ff, x_in;             // value being placed
   rmth_pkg::sample_type moved_ff, moved_in;     // value sent to dest heap
   rmth_pkg::sample_type left_ff, left_in;
   logic [AW:0]          pos_ff, pos_in;         // one bit wider for child calc
   logic                 dropped_ff, dropped_in;
   rmth_pkg::sample_type median_ff, median_in;

   logic                 lo_we, up_we;
   rmth_pkg::addr_type   lo_addr, up_addr;
   rmth_pkg::sample_type lo_wd, up_wd, lo_rd, up_rd;

   rmth_ram #(.WIDTH(rmth_pkg::SAMPLE_WIDTH), .DEPTH(rmth_pkg::HALF_DEPTH)) u_lo (
      .clock(clock), .we(lo_we), .addr(lo_addr), .wdata(lo_wd), .rdata(lo_rd));
   rmth_ram #(.WIDTH(rmth_pkg::SAMPLE_WIDTH), .DEPTH(rmth_pkg::HALF_DEPTH)) u_up (
      .clock(clock), .we(up_we), .addr(up_addr), .wdata(up_wd), .rdata(up_rd));

   rmth_pkg::sample_type src_rd, dst_rd;
   rmth_pkg::size_type   src_n, dst_n;
   logic [AW+1:0]        left_idx, right_idx;
   logic [AW:0]          parent_idx;
   logic                 has_right;
   logic                 pick_right;
   rmth_pkg::sample_type pick_val;
   logic [AW:0]          pick_idx;
   logic [SW:0]          total;
   logic signed [rmth_pkg::SAMPLE_WIDTH:0] sum;
   logic signed [rmth_pkg::SAMPLE_WIDTH:0] half;

   // a above b in heap kind
   function automatic logic above(input logic is_max, input rmth_pkg::sample_type a,
                                  input rmth_pkg::sample_type b);
      above = is_max ? (a > b) : (a < b);
   endfunction

   assign src_rd   = src_lo_ff ? lo_rd : up_rd;
   assign dst_rd   = src_lo_ff ? up_rd : lo_rd;
   assign src_n    = src_lo_ff ? lo_size_ff : up_size_ff;
   assign dst_n    = src_lo_ff ? up_size_ff : lo_size_ff;
   assign left_idx  = {pos_ff, 1'b1};
   assign right_idx = left_idx + 1'b1;
   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign has_right  = right_idx < (AW+2)'(src_n);
   assign pick_right = has_right && above(src_lo_ff, src_rd, left_ff);
   assign pick_val   = pick_right ? src_rd : left_ff;
   assign pick_idx   = pick_right ? right_idx[AW:0] : left_idx[AW:0];
   assign total      = {1'b0, lo_size_ff} + {1'b0, up_size_ff};
   // both tops are read in FIN_RD and valid on the RAM outputs in FIN
   assign sum        = {lo_rd[rmth_pkg::SAMPLE_WIDTH-1], lo_rd}
                     + {up_rd[rmth_pkg::SAMPLE_WIDTH-1], up_rd};
   assign half       = (sum + {{rmth_pkg::SAMPLE_WIDTH{1'b0}}, sum[rmth_pkg::SAMPLE_WIDTH]})
                       >>> 1;

   always_comb begin
      sts.full        = total >= (SW+1)'(rmth_pkg::CAPACITY);
      sts.src_empty   = src_n == '0;
      sts.top_exch    = above(src_lo_ff, src_rd, x_ff);
      sts.dn_has_left = left_idx < (AW+2)'(src_n);
      sts.dn_has_right = has_right;
      sts.dn_swap     = above(src_lo_ff, pick_val, x_ff);
      sts.up_at_root  = pos_ff == '0;
      sts.up_swap     = above(!src_lo_ff, moved_ff, dst_rd);
   end

   // memory port steering
   always_comb begin
      rmth_pkg::addr_type   sa, da;
      logic                 swe, dwe;
      rmth_pkg::sample_type swd, dwd;
      sa = '0; da = '0; swe = 1'b0; dwe = 1'b0; swd = x_ff; dwd = moved_ff;
      if (cmd.ld_top) begin
         sa = '0;
      end
      if (cmd.dn_rd_left) begin
         sa = left_idx[AW-1:0];
      end
      if (cmd.dn_rd_right) begin
         sa = right_idx[AW-1:0];
      end
      if (cmd.dn_step) begin
         sa = pos_ff[AW-1:0]; swe = 1'b1; swd = pick_val;   // child moves up
      end
      if (cmd.dn_end) begin
         sa = pos_ff[AW-1:0]; swe = 1'b1; swd = x_ff;
      end
      if (cmd.up_rd) begin
         da = parent_idx[AW-1:0];
      end
      if (cmd.up_step) begin
         da = pos_ff[AW-1:0]; dwe = 1'b1; dwd = dst_rd;     // parent moves down
      end
      if (cmd.up_end) begin
         da = pos_ff[AW-1:0]; dwe = 1'b1; dwd = moved_ff;
      end
      if (cmd.fin_rd) begin
         sa = '0; da = '0;
      end
      lo_addr = src_lo_ff ? sa : da;  up_addr = src_lo_ff ? da : sa;
      lo_we   = src_lo_ff ? swe : dwe; up_we  = src_lo_ff ? dwe : swe;
      lo_wd   = src_lo_ff ? swd : dwd; up_wd  = src_lo_ff ? dwd : swd;
   end

   always_comb begin
      lo_size_in = lo_size_ff; up_size_in = up_size_ff;
      src_lo_in = src_lo_ff; x_in = x_ff; moved_in = moved_ff;
      left_in = left_ff; pos_in = pos_ff; dropped_in = dropped_ff;
      median_in = median_ff;
      if (cmd.start) begin
         src_lo_in = ~total[0];
         x_in = sample; moved_in = sample; pos_in = '0;
         dropped_in = sts.full;
      end
      if (cmd.ld_top) begin
         moved_in = src_rd;      // exchange: old top leaves
      end
      if (cmd.dn_rd_right) begin
         left_in = src_rd;
      end
      if (cmd.dn_step) begin
         pos_in = pick_idx;
      end
      if (cmd.up_begin) begin
         pos_in = (AW+1)'(dst_n);
      end
      if (cmd.up_step) begin
         pos_in = parent_idx;
      end
      if (cmd.up_end) begin
         if (src_lo_ff) begin
            up_size_in = up_size_ff + 1'b1;
         end else begin
            lo_size_in = lo_size_ff + 1'b1;
         end
      end
      if (cmd.fin) begin
         if (total[0]) begin
            median_in = up_rd;
         end else if (lo_size_ff != '0) begin
            median_in = half[rmth_pkg::SAMPLE_WIDTH-1:0];
         end else begin
            median_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_size_ff <= '0;
         up_size_ff <= '0;
      end else begin
         lo_size_ff <= lo_size_in;
         up_size_ff <= up_size_in;
      end
      src_lo_ff <= src_lo_in; x_ff <= x_in; moved_ff <= moved_in;
      left_ff <= left_in; pos_ff <= pos_in; dropped_ff <= dropped_in;
      median_ff <= median_in;
   end

   assign median  = median_ff;
   assign count   = rmth_pkg::COUNT_WIDTH'(total);
   assign dropped = dropped_ff;

   // min-heap holds ceil(n/2) samples
   property p_sizes_balanced;
      @(posedge clock) disable iff (reset)
         (up_size_ff == lo_size_ff) || (up_size_ff == lo_size_ff + 1'b1);
   endproperty
   a_sizes_balanced: assert property (p_sizes_balanced) else $error("heap sizes out of balance");

   a_grow_one: assert property (@(posedge clock) disable iff (reset)
      cmd.up_end |=> total == $past(total) + 1'b1) else $error("count grew wrong");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && sts.full) |=> dropped_ff) else $error("full not flagged");
endmodule

// ===== sv/rmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmth_ctrl: sequencer for one insert
// Exchange with source top, sift-down, sift-up on destination, median (only median when full).
// ----------------------------------------------------------------------------
module rmth_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rmth_pkg::sts_type sts,
   output rmth_pkg::cmd_type cmd
);
   rmth_pkg::state_type state_ff, state_in;
   logic                out_ff, out_in;   // result waiting

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmth_pkg::ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff;
      cmd = '0;
      req_tready = 1'b0;
      if (out_ff && rsp_tready) begin
         out_in = 1'b0;
      end
      case (state_ff)
         rmth_pkg::ST_IDLE: begin
            req_tready = !out_ff;
            if (req_tvalid && !out_ff) begin
               cmd.start = 1'b1;
               state_in = sts.full ? rmth_pkg::ST_FIN_RD : rmth_pkg::ST_TOP_RD;
            end
         end
         rmth_pkg::ST_TOP_RD: begin
            state_in = sts.src_empty ? rmth_pkg::ST_UP_RD : rmth_pkg::ST_TOP_CHK;
            if (sts.src_empty) begin
               cmd.up_begin = 1'b1;
            end
         end
         rmth_pkg::ST_TOP_CHK: begin
            if (sts.top_exch) begin
               cmd.ld_top = 1'b1;
               state_in = rmth_pkg::ST_DN_RD;
            end else begin
               cmd.up_begin = 1'b1;
               state_in = rmth_pkg::ST_UP_RD;
            end
         end
         rmth_pkg::ST_DN_RD: begin
            if (sts.dn_has_left) begin
               cmd.dn_rd_left = 1'b1;
               state_in = rmth_pkg::ST_DN_RD2;
            end else begin
               cmd.dn_end = 1'b1;
               cmd.up_begin = 1'b1;
               state_in = rmth_pkg::ST_UP_RD;
            end
         end
         rmth_pkg::ST_DN_RD2: begin
            cmd.dn_rd_right = 1'b1;   // latches left value
            state_in = rmth_pkg::ST_DN_CHK;
         end
         rmth_pkg::ST_DN_CHK: begin
            if (sts.dn_swap) begin
               cmd.dn_step = 1'b1;
               state_in = rmth_pkg::ST_DN_RD;
            end else begin
               cmd.dn_end = 1'b1;
               cmd.up_begin = 1'b1;
               state_in = rmth_pkg::ST_UP_RD;
            end
         end
         rmth_pkg::ST_UP_RD: begin
            if (sts.up_at_root) begin
               cmd.up_end = 1'b1;
               state_in = rmth_pkg::ST_FIN_RD;
            end else begin
               cmd.up_rd = 1'b1;
               state_in = rmth_pkg::ST_UP_CHK;
            end
         end
         rmth_pkg::ST_UP_CHK: begin
            if (sts.up_swap) begin
               cmd.up_step = 1'b1;
               state_in = rmth_pkg::ST_UP_RD;
            end else begin
               cmd.up_end = 1'b1;
               state_in = rmth_pkg::ST_FIN_RD;
            end
         end
         rmth_pkg::ST_FIN_RD: begin
            cmd.fin_rd = 1'b1;
            state_in = rmth_pkg::ST_FIN;
         end
         rmth_pkg::ST_FIN: begin
            cmd.fin = 1'b1;
            state_in = rmth_pkg::ST_OUT;
         end
         rmth_pkg::ST_OUT: begin
            if (!out_ff || rsp_tready) begin
               out_in = 1'b1;
               state_in = rmth_pkg::ST_IDLE;
            end
         end
         default: state_in = rmth_pkg::ST_IDLE;
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == rmth_pkg::ST_IDLE)) else $error("start outside idle");
   a_fin_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> state_ff == rmth_pkg::ST_OUT) else $error("fin not followed by out");
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !out_ff) else $error("start with result pending");
endmodule
